[hdl/bpot_pkg.sv]
// Package for the bounded priority offer table: codes, payload types, state
// encoding and the preference compare. No dependencies.
`timescale 1ns / 1ps

package bpot_pkg;

  // Default table depth and fixed field widths.
  localparam int unsigned BPOT_DEPTH = 16;
  localparam int unsigned BPOT_CAP_W = 5;
  localparam int unsigned BPOT_IDX_W = 4;
  localparam logic [BPOT_CAP_W-1:0] BPOT_CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } bpot_cmd_e;

  typedef enum logic [1:0] {
    AV_HIDDEN  = 2'd0,
    AV_AVAIL   = 2'd1,
    AV_UNAVAIL = 2'd2
  } bpot_avail_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_RESP
  } bpot_state_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [15:0]        action_key;
    logic               offer_safe;
    logic [1:0]         availability;
    logic               explain_flag;
    logic signed [31:0] priority_req;
    logic [31:0]        revision;
    logic [15:0]        reason_key;
    logic               reason_safe;
    logic [3:0]         read_index;
  } bpot_in_t;

  typedef struct packed {
    logic               accepted;
    logic [4:0]         entry_count;
    logic [15:0]        out_key;
    logic [1:0]         out_availability;
    logic signed [31:0] out_priority;
    logic [31:0]        out_revision;
    logic [15:0]        out_reason_key;
    logic               out_reason_present;
  } bpot_out_t;

  typedef struct packed {
    logic [15:0]        key;
    logic [1:0]         avail;
    logic signed [31:0] prio;
    logic [31:0]        rev;
    logic               rsn_present;
    logic [15:0]        rsn_key;
  } bpot_entry_t;

  // True if offer a is preferred over offer b: higher priority, then smaller key.
  function automatic logic bpot_prefers(logic signed [31:0] pa, logic [15:0] ka,
                                        logic signed [31:0] pb, logic [15:0] kb);
    logic res;
    if (pa != pb) begin
      res = (pa > pb);
    end else begin
      res = (ka < kb);
    end
    return res;
  endfunction

endpackage

[hdl/bpot_chan_if.sv]
// Valid/ready channel interface for the offer table, one payload type per
// instance. Payload types come from bpot_pkg.
`timescale 1ns / 1ps

interface bpot_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/bounded_priority_offer_table.sv]
// Top level of the bounded priority offer table: sequencer, entry memory and
// shared preference compare. Depends on bpot_pkg and bpot_chan_if.
`timescale 1ns / 1ps

// Usage
// The block holds up to DEPTH offers and takes one command item at a time on
// in_i: insert, clear, read or no operation. Each command item gives exactly
// one result item on out_o, carrying the accepted flag, the entry count after
// the command and, for a read of a held slot, that slot's contents.
// cfg_i writes the capacity register; it is always ready and must only be
// written while the block is idle.
// An insert walks the held entries once through the single read port of the
// entry memory, one entry per cycle, looking for a duplicate key and tracking
// the least preferred entry with one shared compare unit. That compare unit
// then decides an eviction. An insert that passes its checks goes through the
// scan and decide states before its response state; a rejected insert, a clear,
// a read or a no operation goes straight to the response state.
// in_i is ready only while the sequencer is idle. The result sits in an output
// register, so the next item is accepted while an earlier result waits; a
// stalled receiver holds the block only when a new result is ready to be
// written. Reset empties the table (count zero) and sets the capacity to 16;
// the memory itself is not cleared, since slots beyond the count are never
// reported.
module bounded_priority_offer_table import bpot_pkg::*; #(
  parameter int unsigned DEPTH = BPOT_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bpot_chan_if.sink   in_i,
  bpot_chan_if.source out_o,
  bpot_chan_if.sink   cfg_i
);

  // Count width holds DEPTH itself; index width addresses the memory.
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CMPW = (CW > BPOT_CAP_W) ? CW : BPOT_CAP_W;
  localparam int unsigned RW   = (CW > BPOT_IDX_W) ? CW : BPOT_IDX_W;

  bpot_state_e state_q, state_d;

  logic [CW-1:0]         fill_q, fill_d;
  logic [BPOT_CAP_W-1:0] max_q;
  bpot_entry_t           new_q, new_d;
  logic [CW-1:0]         ptr_q, ptr_d;
  logic                  pv_q, pv_d;
  logic [IW-1:0]         pidx_q, pidx_d;
  logic                  dup_q, dup_d;
  logic [IW-1:0]         dup_idx_q, dup_idx_d;
  logic [1:0]            dup_av_q, dup_av_d;
  logic [31:0]           dup_rev_q, dup_rev_d;
  logic [IW-1:0]         worst_idx_q, worst_idx_d;
  logic signed [31:0]    worst_prio_q, worst_prio_d;
  logic [15:0]           worst_key_q, worst_key_d;
  logic                  acc_q, acc_d;
  logic                  hit_q, hit_d;
  logic                  out_vld_q, out_vld_d;
  bpot_out_t             out_data_q, out_data_d;

  // Entry memory: one write port, one registered read port.
  bpot_entry_t mem [DEPTH];
  bpot_entry_t rdata_q;
  logic        mem_we;
  logic [IW-1:0] mem_waddr;
  bpot_entry_t mem_wdata;
  logic        mem_re;
  logic [IW-1:0] mem_raddr;

  // Shared preference compare.
  logic signed [31:0] cmp_pa, cmp_pb;
  logic [15:0]        cmp_ka, cmp_kb;
  logic               cmp_pref;

  logic            in_fire;
  logic            out_free;
  logic            reject;
  logic [CMPW-1:0] cap;
  logic            fail_closed;
  logic            newer;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_free    = !out_vld_q || out_o.ready;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_data_q;
  assign cfg_i.ready = 1'b1;

  assign cap = (CMPW'(max_q) > CMPW'(DEPTH)) ? CMPW'(DEPTH) : CMPW'(max_q);

  // An insert is refused up front for zero capacity, an unsafe offer, a hidden
  // or unknown availability, or an unavailable offer that may not be shown.
  always_comb begin
    reject = (cap == '0) || !in_i.data.offer_safe ||
             ((in_i.data.availability != AV_AVAIL) &&
              (in_i.data.availability != AV_UNAVAIL)) ||
             ((in_i.data.availability == AV_UNAVAIL) && !in_i.data.explain_flag);
  end

  assign cmp_pref = bpot_prefers(cmp_pa, cmp_ka, cmp_pb, cmp_kb);

  // A duplicate is replaced when it fails closed or carries a newer revision.
  assign fail_closed = (new_q.avail == AV_UNAVAIL) && (dup_av_q == AV_AVAIL);
  assign newer       = (new_q.avail == dup_av_q) && (new_q.rev > dup_rev_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if ((in_i.data.cmd == CMD_INSERT) && !reject) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (ptr_q >= fill_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    fill_d       = fill_q;
    new_d        = new_q;
    ptr_d        = ptr_q;
    pv_d         = pv_q;
    pidx_d       = pidx_q;
    dup_d        = dup_q;
    dup_idx_d    = dup_idx_q;
    dup_av_d     = dup_av_q;
    dup_rev_d    = dup_rev_q;
    worst_idx_d  = worst_idx_q;
    worst_prio_d = worst_prio_q;
    worst_key_d  = worst_key_q;
    acc_d        = acc_q;
    hit_d        = hit_q;
    out_data_d   = out_data_q;
    out_vld_d    = out_vld_q && !out_o.ready;
    mem_we       = 1'b0;
    mem_waddr    = dup_idx_q;
    mem_wdata    = new_q;
    mem_re       = 1'b0;
    mem_raddr    = ptr_q[IW-1:0];
    cmp_pa       = worst_prio_q;
    cmp_ka       = worst_key_q;
    cmp_pb       = rdata_q.prio;
    cmp_kb       = rdata_q.key;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          acc_d = 1'b0;
          hit_d = 1'b0;
          ptr_d = '0;
          pv_d  = 1'b0;
          dup_d = 1'b0;
          new_d.key   = in_i.data.action_key;
          new_d.avail = in_i.data.availability;
          new_d.prio  = in_i.data.priority_req;
          new_d.rev   = in_i.data.revision;
          if ((in_i.data.availability == AV_AVAIL) || !in_i.data.reason_safe) begin
            new_d.rsn_present = 1'b0;
            new_d.rsn_key     = '0;
          end else begin
            new_d.rsn_present = 1'b1;
            new_d.rsn_key     = in_i.data.reason_key;
          end
          case (in_i.data.cmd)
            CMD_CLEAR: begin
              fill_d = '0;
            end
            CMD_READ: begin
              mem_re    = 1'b1;
              mem_raddr = IW'(in_i.data.read_index);
              hit_d     = RW'(in_i.data.read_index) < RW'(fill_q);
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Issue the next read while the previous entry is evaluated.
        if (ptr_q < fill_q) begin
          mem_re = 1'b1;
          pv_d   = 1'b1;
          pidx_d = ptr_q[IW-1:0];
          ptr_d  = CW'(ptr_q + 1'b1);
        end else begin
          pv_d = 1'b0;
        end
        if (pv_q) begin
          if ((rdata_q.key == new_q.key) && !dup_q) begin
            dup_d     = 1'b1;
            dup_idx_d = pidx_q;
            dup_av_d  = rdata_q.avail;
            dup_rev_d = rdata_q.rev;
          end
          if ((pidx_q == '0) || cmp_pref) begin
            worst_idx_d  = pidx_q;
            worst_prio_d = rdata_q.prio;
            worst_key_d  = rdata_q.key;
          end
        end
      end
      ST_DECIDE: begin
        cmp_pa = new_q.prio;
        cmp_ka = new_q.key;
        cmp_pb = worst_prio_q;
        cmp_kb = worst_key_q;
        if (dup_q) begin
          if (fail_closed || newer) begin
            mem_we    = 1'b1;
            mem_waddr = dup_idx_q;
            acc_d     = 1'b1;
          end
        end else if (CMPW'(fill_q) < cap) begin
          mem_we    = 1'b1;
          mem_waddr = fill_q[IW-1:0];
          fill_d    = CW'(fill_q + 1'b1);
          acc_d     = 1'b1;
        end else if (cmp_pref) begin
          mem_we    = 1'b1;
          mem_waddr = worst_idx_q;
          acc_d     = 1'b1;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_vld_d                     = 1'b1;
          out_data_d.accepted           = acc_q;
          out_data_d.entry_count        = BPOT_CAP_W'(fill_q);
          out_data_d.out_key            = hit_q ? rdata_q.key : '0;
          out_data_d.out_availability   = hit_q ? rdata_q.avail : '0;
          out_data_d.out_priority       = hit_q ? rdata_q.prio : '0;
          out_data_d.out_revision       = hit_q ? rdata_q.rev : '0;
          out_data_d.out_reason_key     = hit_q ? rdata_q.rsn_key : '0;
          out_data_d.out_reason_present = hit_q ? rdata_q.rsn_present : 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      max_q     <= BPOT_CAP_RESET;
      out_vld_q <= 1'b0;
      pv_q      <= 1'b0;
      dup_q     <= 1'b0;
      ptr_q     <= '0;
      acc_q     <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      out_vld_q <= out_vld_d;
      pv_q      <= pv_d;
      dup_q     <= dup_d;
      ptr_q     <= ptr_d;
      acc_q     <= acc_d;
      hit_q     <= hit_d;
      if (cfg_i.valid) begin
        max_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    new_q        <= new_d;
    pidx_q       <= pidx_d;
    dup_idx_q    <= dup_idx_d;
    dup_av_q     <= dup_av_d;
    dup_rev_q    <= dup_rev_d;
    worst_idx_q  <= worst_idx_d;
    worst_prio_q <= worst_prio_d;
    worst_key_q  <= worst_key_d;
    out_data_q   <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // The entry count never exceeds the table depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(DEPTH))
    else $error("entry count beyond table depth");

  // The count only grows by one per insert or drops to zero on a clear.
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> ((fill_q == '0) ||
                                   (fill_q == CW'($past(fill_q) + 1'b1))))
    else $error("entry count changed by more than one");

  // A new result is only loaded from the response state.
  a_resp_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !$past(out_vld_q)) |-> ($past(state_q) == ST_RESP))
    else $error("result raised outside the response state");

  // The memory is written only while deciding an insert.
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_DECIDE))
    else $error("entry memory written outside the decide state");

endmodule

[test/bpot_table_checker.sv]
// Scoreboard for the bounded priority offer table: watches the command, result
// and capacity channels, predicts every result and compares it field by field.
// Depends on bpot_pkg and bpot_chan_if.
`timescale 1ns / 1ps

module bpot_table_checker import bpot_pkg::*; #(
  parameter int unsigned DEPTH = BPOT_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  bpot_chan_if cmd_mon_i,
  bpot_chan_if rsp_mon_i,
  bpot_chan_if cfg_mon_i,
  output int   pending_o,
  output int   fail_count_o
);

  // Shadow copy of the table, the fill level and the capacity register.
  bpot_entry_t             offer_tbl [DEPTH];
  int unsigned             fill_level;
  logic [BPOT_CAP_W-1:0]   cap_reg;
  bpot_out_t               expected_rsp [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%08h, want 0x%08h", name, got, want));
    end
  endtask

  // Higher signed priority wins; on a tie the smaller key wins.
  function automatic logic offer_beats(input logic signed [31:0] prio_a,
                                       input logic [15:0] key_a,
                                       input logic signed [31:0] prio_b,
                                       input logic [15:0] key_b);
    if (prio_a != prio_b) begin
      return prio_a > prio_b;
    end
    return key_a < key_b;
  endfunction

  function automatic logic insert_offer(input bpot_in_t it);
    int unsigned cap;
    int unsigned worst;
    bpot_entry_t cand;
    logic        fail_closed;
    logic        newer;

    cap = (cap_reg > DEPTH) ? DEPTH : cap_reg;
    if (cap == 0 || !it.offer_safe) begin
      return 1'b0;
    end
    if (it.availability != AV_AVAIL && it.availability != AV_UNAVAIL) begin
      return 1'b0;
    end
    if (it.availability == AV_UNAVAIL && !it.explain_flag) begin
      return 1'b0;
    end

    cand.key         = it.action_key;
    cand.avail       = it.availability;
    cand.prio        = it.priority_req;
    cand.rev         = it.revision;
    cand.rsn_present = (it.availability == AV_UNAVAIL) && it.reason_safe;
    cand.rsn_key     = cand.rsn_present ? it.reason_key : 16'h0000;

    for (int unsigned i = 0; i < fill_level; i++) begin
      if (offer_tbl[i].key == it.action_key) begin
        fail_closed = (cand.avail == AV_UNAVAIL) && (offer_tbl[i].avail == AV_AVAIL);
        newer = (cand.avail == offer_tbl[i].avail) && (cand.rev > offer_tbl[i].rev);
        if (!fail_closed && !newer) begin
          return 1'b0;
        end
        offer_tbl[i] = cand;
        return 1'b1;
      end
    end

    if (fill_level < cap) begin
      offer_tbl[fill_level] = cand;
      fill_level++;
      return 1'b1;
    end

    // Full (or held above a lowered capacity): compete with the worst entry.
    worst = 0;
    for (int unsigned i = 1; i < fill_level; i++) begin
      if (offer_beats(offer_tbl[worst].prio, offer_tbl[worst].key,
                      offer_tbl[i].prio, offer_tbl[i].key)) begin
        worst = i;
      end
    end
    if (!offer_beats(cand.prio, cand.key, offer_tbl[worst].prio, offer_tbl[worst].key)) begin
      return 1'b0;
    end
    offer_tbl[worst] = cand;
    return 1'b1;
  endfunction

  function automatic bpot_out_t apply_command(input bpot_in_t it);
    bpot_out_t rsp;
    rsp = '0;
    case (it.cmd)
      CMD_INSERT: begin
        rsp.accepted = insert_offer(it);
      end
      CMD_CLEAR: begin
        fill_level = 0;
      end
      CMD_READ: begin
        if (it.read_index < fill_level) begin
          rsp.out_key            = offer_tbl[it.read_index].key;
          rsp.out_availability   = offer_tbl[it.read_index].avail;
          rsp.out_priority       = offer_tbl[it.read_index].prio;
          rsp.out_revision       = offer_tbl[it.read_index].rev;
          rsp.out_reason_key     = offer_tbl[it.read_index].rsn_key;
          rsp.out_reason_present = offer_tbl[it.read_index].rsn_present;
        end
      end
      default: begin
      end
    endcase
    rsp.entry_count = BPOT_CAP_W'(fill_level);
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bpot_out_t want;
    bpot_out_t got;
    if (!rst_ni) begin
      fill_level   = 0;
      cap_reg      = BPOT_CAP_RESET;
      fail_count_o = 0;
      expected_rsp.delete();
      pending_o <= 0;
    end else begin
      // Results are matched before new items are predicted, so a result can
      // only ever pair with an item accepted on an earlier edge.
      if (rsp_mon_i.valid && rsp_mon_i.ready) begin
        got = rsp_mon_i.data;
        if (expected_rsp.size() == 0) begin
          report_mismatch("result item with no item outstanding");
        end else begin
          want = expected_rsp.pop_front();
          check_field("accepted", 32'(got.accepted), 32'(want.accepted));
          check_field("entry_count", 32'(got.entry_count), 32'(want.entry_count));
          check_field("out_key", 32'(got.out_key), 32'(want.out_key));
          check_field("out_availability", 32'(got.out_availability),
                      32'(want.out_availability));
          check_field("out_priority", got.out_priority, want.out_priority);
          check_field("out_revision", got.out_revision, want.out_revision);
          check_field("out_reason_key", 32'(got.out_reason_key), 32'(want.out_reason_key));
          check_field("out_reason_present", 32'(got.out_reason_present),
                      32'(want.out_reason_present));
        end
      end
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        cap_reg = cfg_mon_i.data;
      end
      if (cmd_mon_i.valid && cmd_mon_i.ready) begin
        expected_rsp.push_back(apply_command(cmd_mon_i.data));
      end
      pending_o <= expected_rsp.size();
    end
  end

endmodule

[test/tb_bounded_priority_offer_table.sv]
// Testbench top for the bounded priority offer table: clock, reset, command
// and capacity stimulus, result back-pressure and the final verdict.
// Depends on bpot_pkg, bpot_chan_if, the block and bpot_table_checker.
`timescale 1ns / 1ps

module tb_bounded_priority_offer_table;
  import bpot_pkg::*;

  localparam int unsigned DEPTH        = BPOT_DEPTH;
  localparam int unsigned PHASE_ITEMS  = 135;
  localparam int unsigned NUM_PHASES   = 10;
  localparam int unsigned STEADY_PHASE = 4;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // When set, neither the sender nor the receiver inserts idle cycles.
  logic steady_flow = 1'b0;

  int pending_rsp;
  int fail_count;

  bpot_chan_if #(.T(bpot_in_t))              cmd_bus ();
  bpot_chan_if #(.T(bpot_out_t))             rsp_bus ();
  bpot_chan_if #(.T(logic [BPOT_CAP_W-1:0])) cfg_bus ();

  bounded_priority_offer_table #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_bus),
    .out_o (rsp_bus),
    .cfg_i (cfg_bus)
  );

  bpot_table_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_mon_i   (cmd_bus),
    .rsp_mon_i   (rsp_bus),
    .cfg_mon_i   (cfg_bus),
    .pending_o   (pending_rsp),
    .fail_count_o(fail_count)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver stalls in about a third of the cycles, except during the
  // steady stretch where it is always ready.
  always @(posedge clk_i) begin
    rsp_bus.ready <= steady_flow || ($urandom_range(0, 99) >= 34);
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

  // A command with every field random, then forced to the given operation.
  // Fields that the operation ignores stay random so their bits still toggle.
  function automatic bpot_in_t command(input bpot_cmd_e op, input logic [3:0] idx);
    bpot_in_t c;
    c.cmd          = op;
    c.action_key   = 16'($urandom_range(0, 65535));
    c.offer_safe   = 1'($urandom_range(0, 1));
    c.availability = 2'($urandom_range(0, 3));
    c.explain_flag = 1'($urandom_range(0, 1));
    c.priority_req = $urandom();
    c.revision     = $urandom();
    c.reason_key   = 16'($urandom_range(0, 65535));
    c.reason_safe  = 1'($urandom_range(0, 1));
    c.read_index   = idx;
    return c;
  endfunction

  // A well-formed insert that passes the safety checks; the caller breaks it
  // afterwards where a directed case needs that.
  function automatic bpot_in_t offer(input logic [15:0] key, input logic [1:0] av,
                                     input logic signed [31:0] prio,
                                     input logic [31:0] rev);
    bpot_in_t c;
    c = command(CMD_INSERT, 4'($urandom_range(0, 15)));
    c.action_key   = key;
    c.availability = av;
    c.priority_req = prio;
    c.revision     = rev;
    c.offer_safe   = 1'b1;
    c.explain_flag = 1'b1;
    c.reason_safe  = 1'b1;
    return c;
  endfunction

  // Random traffic. Keys come mostly from a small pool so that duplicates,
  // full tables and evictions are frequent; priorities come mostly from a
  // narrow band so that ties fall back to the key compare.
  function automatic bpot_in_t random_command();
    bpot_in_t    c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 64) begin
      c = command(CMD_INSERT, 4'($urandom_range(0, 15)));
    end else if (pick < 69) begin
      c = command(CMD_CLEAR, 4'($urandom_range(0, 15)));
    end else if (pick < 96) begin
      c = command(CMD_READ, 4'($urandom_range(0, 15)));
    end else begin
      c = command(CMD_NOP, 4'($urandom_range(0, 15)));
    end

    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      c.action_key = 16'($urandom_range(0, 23));
    end else if (pick < 92) begin
      c.action_key = 16'hFFFF - 16'($urandom_range(0, 3));
    end

    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      c.availability = AV_AVAIL;
    end else if (pick < 85) begin
      c.availability = AV_UNAVAIL;
    end else if (pick < 93) begin
      c.availability = AV_HIDDEN;
    end

    c.offer_safe   = ($urandom_range(0, 99) < 90);
    c.explain_flag = ($urandom_range(0, 99) < 88);
    c.reason_safe  = ($urandom_range(0, 99) < 70);

    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      c.priority_req = 32'(int'($urandom_range(0, 6)) - 3);
    end else if (pick < 75) begin
      c.priority_req = 32'sh7FFFFFFF;
    end else if (pick < 80) begin
      c.priority_req = 32'sh80000000;
    end

    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      c.revision = 32'($urandom_range(0, 7));
    end else if (pick < 85) begin
      c.revision = 32'hFFFFFFFF - 32'($urandom_range(0, 1));
    end
    return c;
  endfunction

  // Offers one item and returns at the edge where it is taken. Valid is only
  // lowered when a gap is inserted, so it never drops and rises in one step.
  task automatic send_item(input bpot_in_t it);
    int unsigned gap;
    gap = 0;
    if (!steady_flow && $urandom_range(0, 99) < 34) begin
      gap = $urandom_range(1, 6);
    end
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.data  <= it;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
  endtask

  // Stops sending and waits until every outstanding result has come back.
  // The first edge lets the checker count the item taken at this edge.
  task automatic drain_results();
    cmd_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp != 0) @(posedge clk_i);
  endtask

  // Capacity writes happen only with the block idle.
  task automatic write_capacity(input logic [BPOT_CAP_W-1:0] cap);
    drain_results();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= cap;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [BPOT_CAP_W-1:0] phase_caps [NUM_PHASES];
    bpot_in_t              it;

    // Every phase but the first keeps what the previous one left in the
    // table, so lowering the capacity leaves it holding more than allowed.
    phase_caps = '{5'd0, 5'd16, 5'd3, 5'd1, 5'd8, 5'd2, 5'd31, 5'd16, 5'd5, 5'd12};

    cmd_bus.valid <= 1'b0;
    cmd_bus.data  <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.data  <= '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, at the reset capacity of 16.
    // A read of an empty table reports zeros.
    send_item(command(CMD_READ, 4'd0));
    // Smallest key with the highest priority, available.
    send_item(offer(16'h0000, AV_AVAIL, 32'sh7FFFFFFF, 32'h0000_0000));
    // Largest key, lowest priority, newest revision, unavailable with a reason.
    it = offer(16'hFFFF, AV_UNAVAIL, 32'sh80000000, 32'hFFFF_FFFF);
    it.reason_key = 16'hFFFF;
    send_item(it);
    // Unavailable, but the reason is not a proper reason: it is dropped.
    it = offer(16'h1234, AV_UNAVAIL, 32'sd0, 32'd1);
    it.reason_safe = 1'b0;
    it.reason_key  = 16'hFFFF;
    send_item(it);
    // Available offers never keep a reason, even a proper one.
    it = offer(16'h2222, AV_AVAIL, 32'sd5, 32'd5);
    it.reason_key = 16'hABCD;
    send_item(it);
    // The four rejections: unsafe, hidden, the unused availability code, and
    // unavailable without permission to explain.
    it = offer(16'h3333, AV_AVAIL, 32'sd1, 32'd1);
    it.offer_safe = 1'b0;
    send_item(it);
    send_item(offer(16'h3333, AV_HIDDEN, 32'sd1, 32'd1));
    send_item(offer(16'h3333, AV_AVAIL | AV_UNAVAIL, 32'sd1, 32'd1));
    it = offer(16'h3333, AV_UNAVAIL, 32'sd1, 32'd1);
    it.explain_flag = 1'b0;
    send_item(it);
    // Duplicate key: same revision is refused, a newer one replaces, going
    // unavailable replaces regardless of revision, going back is refused.
    send_item(offer(16'h2222, AV_AVAIL, 32'sd9, 32'd5));
    send_item(offer(16'h2222, AV_AVAIL, 32'sd9, 32'd6));
    send_item(offer(16'h2222, AV_UNAVAIL, 32'sd2, 32'd0));
    send_item(offer(16'h2222, AV_AVAIL, 32'sd2, 32'hFFFF_FFFF));
    // Read back every held slot, one past the end and the last index.
    for (int i = 0; i < 5; i++) begin
      send_item(command(CMD_READ, 4'(i)));
    end
    send_item(command(CMD_READ, 4'd15));
    send_item(command(CMD_NOP, 4'd0));
    send_item(command(CMD_CLEAR, 4'd0));
    send_item(command(CMD_READ, 4'd0));

    // Random part, one phase per capacity setting. Each capacity write waits
    // for the block to drain, which also pauses the sender until every
    // outstanding result has arrived. One phase runs with no idling at all.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(phase_caps[p]);
      steady_flow <= (p == STEADY_PHASE);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(random_command());
      end
    end

    drain_results();
    steady_flow <= 1'b0;
    repeat (DEPTH + 8) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
